### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the radix digit emitter.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rde: implication check failed");

// Next-cycle implication, checked outside reset.
`define RDE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rde: next-cycle check failed");

`endif

### rtl/rde_pkg.sv
// Package for the radix digit emitter: widths, radix limits, state type,
// divider status struct and the digit-to-symbol function. No dependencies.
package rde_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int IN_VALUE_W     = 64;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd62;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RD,
        ST_OUT,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // '0'-'9', then 'A'-'Z', then 'a'-'z'; codes above 61 map to zero
    function automatic logic [CHAR_W-1:0] sym_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d < 6'd10) begin
            sym_char = 7'd48 + dx;
        end else if (d < 6'd36) begin
            sym_char = 7'd55 + dx;
        end else if (d < 6'd62) begin
            sym_char = 7'd61 + dx;
        end else begin
            sym_char = '0;
        end
    endfunction

endpackage

### rtl/radix_digit_emitter.sv
// Top level of the radix digit emitter: sequencer, digit store and output stage.
// Depends on rde_pkg, rde_divider and assert_macros.svh.
//
// Usage:
//   Input stream (i_s_*): one transaction carries a value and a radix. The
//   block takes a transaction only when idle and then keeps o_s_tready low
//   until every digit of that value has been handed over.
//   Output stream (o_m_*): one transaction per digit, most significant first,
//   ASCII symbols 0-9, A-Z, a-z; o_m_tuser[0] marks the final digit.
//   A radix outside 2..62 gives one transaction with o_m_tuser[1] set and a
//   zero character. A zero value gives no transaction at all.
//   Sequence: each digit costs one shared bit-serial divider pass, framed by a
//   start state and a wait state; once the quotient reaches zero, each digit
//   is read from the digit store and then presented. When the receiver never
//   stalls, the divider loop sets the pace.
//   A stalled receiver simply holds the current digit in the output stage;
//   nothing is lost and the block waits.
//   Reset (synchronous, active low) returns the sequencer to idle and clears
//   the digit count; the digit store needs no clearing.
`include "assert_macros.svh"

module radix_digit_emitter #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // [63:0] value, [69:64] radix, [71:70] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] digit_char, [7] zero
    output logic [1:0]  o_m_tuser    // [0] last_digit, [1] bad_radix
);

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    rde_pkg::t_state r_state, n_state;

    logic [VALUE_BITS-1:0]       r_value;
    logic [rde_pkg::RADIX_W-1:0] r_radix;
    logic [CNT_W-1:0]            r_count;
    logic [rde_pkg::RADIX_W-1:0] r_rd_data;
    logic [rde_pkg::RADIX_W-1:0] digit_mem [VALUE_BITS];

    logic [VALUE_BITS-1:0]       in_value;
    logic [rde_pkg::RADIX_W-1:0] in_radix;
    logic                        s_acc;
    logic                        m_acc;
    logic                        bad_radix_in;
    logic [CNT_W-1:0]            cnt_m1;

    logic                        div_start;
    logic                        wr_en;
    logic                        rd_en;
    rde_pkg::t_div_stat          div_stat;
    logic [VALUE_BITS-1:0]       div_quot;
    logic [rde_pkg::RADIX_W-1:0] div_rem;

    assign in_value     = i_s_tdata[VALUE_BITS-1:0];
    assign in_radix     = i_s_tdata[rde_pkg::IN_VALUE_W +: rde_pkg::RADIX_W];
    assign s_acc        = i_s_tvalid && o_s_tready;
    assign m_acc        = o_m_tvalid && i_m_tready;
    assign bad_radix_in = (in_radix < rde_pkg::RADIX_MIN) || (in_radix > rde_pkg::RADIX_MAX);
    assign cnt_m1       = r_count - CNT_W'(1);

    rde_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_value),
        .i_divisor   (r_radix),
        .o_stat      (div_stat),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rde_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (bad_radix_in) begin
                        n_state = rde_pkg::ST_ERR;
                    end else if (in_value != '0) begin
                        n_state = rde_pkg::ST_DIV_START;
                    end
                end
            end
            rde_pkg::ST_DIV_START: begin
                n_state = rde_pkg::ST_DIV_WAIT;
            end
            rde_pkg::ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    n_state = (div_quot == '0) ? rde_pkg::ST_RD : rde_pkg::ST_DIV_START;
                end
            end
            rde_pkg::ST_RD: begin
                n_state = rde_pkg::ST_OUT;
            end
            rde_pkg::ST_OUT: begin
                if (m_acc) begin
                    n_state = (r_count == CNT_W'(1)) ? rde_pkg::ST_IDLE : rde_pkg::ST_RD;
                end
            end
            rde_pkg::ST_ERR: begin
                if (m_acc) begin
                    n_state = rde_pkg::ST_IDLE;
                end
            end
            default: n_state = rde_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_m_tdata  = '0;
        o_m_tuser  = '0;
        div_start  = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        unique case (r_state)
            rde_pkg::ST_IDLE:      o_s_tready = 1'b1;
            rde_pkg::ST_DIV_START: div_start  = 1'b1;
            rde_pkg::ST_DIV_WAIT:  wr_en      = div_stat.done;
            rde_pkg::ST_RD:        rd_en      = 1'b1;
            rde_pkg::ST_OUT: begin
                o_m_tvalid = 1'b1;
                o_m_tdata  = {1'b0, rde_pkg::sym_char(r_rd_data)};
                o_m_tuser  = {1'b0, (r_count == CNT_W'(1))};
            end
            rde_pkg::ST_ERR: begin
                o_m_tvalid = 1'b1;
                o_m_tuser  = 2'b10;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rde_pkg::ST_IDLE;
            r_count <= '0;
            r_value <= '0;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                r_count <= '0;
                r_value <= bad_radix_in ? '0 : in_value;
            end else if (wr_en) begin
                r_count <= r_count + CNT_W'(1);
                r_value <= div_quot;
            end else if (m_acc && (r_state == rde_pkg::ST_OUT)) begin
                r_count <= cnt_m1;
            end
        end
        if (s_acc) begin
            r_radix <= in_radix;
        end
    end

    // digit store: written per remainder, read back from the top down
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            digit_mem[r_count[IDX_W-1:0]] <= div_rem;
        end
        if (rd_en) begin
            r_rd_data <= digit_mem[cnt_m1[IDX_W-1:0]];
        end
    end

    `RDE_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(VALUE_BITS))
    `RDE_ASSERT_IMP(a_out_nonempty, r_state == rde_pkg::ST_OUT, r_count != '0)
    `RDE_ASSERT_NEXT(a_bad_to_err, s_acc && bad_radix_in, r_state == rde_pkg::ST_ERR)
    `RDE_ASSERT_NEXT(a_div_launch, r_state == rde_pkg::ST_DIV_START, div_stat.busy)

endmodule

### rtl/rde_divider.sv
// Restoring divider: one quotient bit per cycle, shifted in over all VALUE_BITS dividend bits.
// Depends on rde_pkg (radix width, status struct) and assert_macros.svh.
`include "assert_macros.svh"

module rde_divider #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [VALUE_BITS-1:0]        i_dividend,
    input  logic [rde_pkg::RADIX_W-1:0]  i_divisor,
    output rde_pkg::t_div_stat           o_stat,
    output logic [VALUE_BITS-1:0]        o_quotient,
    output logic [rde_pkg::RADIX_W-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0]       r_dvd, n_dvd;
    logic [rde_pkg::RADIX_W-1:0] r_rem, n_rem;
    logic [rde_pkg::RADIX_W-1:0] r_div, n_div;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;

    logic [rde_pkg::RADIX_W:0]   rem_sh;
    logic [rde_pkg::RADIX_W:0]   diff;
    logic                        ge;

    always_comb begin
        rem_sh = {r_rem, r_dvd[VALUE_BITS-1]};
        diff   = rem_sh - {1'b0, r_div};
        ge     = rem_sh >= {1'b0, r_div};

        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;

        if (i_start) begin
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = CNT_W'(VALUE_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // partial remainder stays below the divisor, so six bits hold it
            n_rem = ge ? diff[rde_pkg::RADIX_W-1:0] : rem_sh[rde_pkg::RADIX_W-1:0];
            n_dvd = {r_dvd[VALUE_BITS-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_dvd;
    assign o_remainder  = r_rem;

    `RDE_ASSERT_IMP(a_rem_below_div, r_done, r_rem < r_div)
    `RDE_ASSERT_NEXT(a_start_busy, i_start, r_busy && !r_done)

endmodule

### verif/rde_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the radix digit emitter: watches both stream channels, works out
// the digit characters of every accepted value and compares each output transaction.
// Depends on rde_pkg for the radix limits and the default value width.
module rde_checker #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,   // [63:0] value, [69:64] radix, [71:70] zero
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [6:0] digit_char, [7] zero
    input  logic [1:0]  i_m_tuser,   // [0] last_digit, [1] bad_radix
    output int          o_fail_count,
    output int          o_pending,
    output int          o_values_taken,
    output int          o_digits_taken,
    output int          o_bad_radix_taken
);

    typedef struct packed {
        logic [rde_pkg::CHAR_W-1:0] digit_char;
        logic                       last_digit;
        logic                       bad_radix;
    } t_digit_txn;

    localparam logic [62*8-1:0] DIGIT_SYMBOLS =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

    t_digit_txn expected_digits[$];
    int fail_count       = 0;
    int values_taken     = 0;
    int digits_taken     = 0;
    int bad_radix_taken  = 0;
    int pending          = 0;

    assign o_fail_count      = fail_count;
    assign o_pending         = pending;
    assign o_values_taken    = values_taken;
    assign o_digits_taken    = digits_taken;
    assign o_bad_radix_taken = bad_radix_taken;

    function automatic logic [rde_pkg::CHAR_W-1:0] digit_symbol(
        input logic [rde_pkg::RADIX_W-1:0] d
    );
        logic [7:0] ch;
        ch = DIGIT_SYMBOLS[(61 - d) * 8 +: 8];
        return ch[rde_pkg::CHAR_W-1:0];
    endfunction

    // Divide repeatedly, then queue the remainders most significant first.
    function automatic void convert_value(input logic [63:0] value,
                                          input logic [rde_pkg::RADIX_W-1:0] radix);
        logic [63:0]                 quotient;
        logic [rde_pkg::RADIX_W-1:0] remainders [0:63];
        int                          n;
        t_digit_txn                  txn;
        if (radix < rde_pkg::RADIX_MIN || radix > rde_pkg::RADIX_MAX) begin
            txn = '{digit_char: '0, last_digit: 1'b0, bad_radix: 1'b1};
            expected_digits.push_back(txn);
            return;
        end
        quotient = value & VALUE_MASK;
        n = 0;
        while (quotient != 0 && n < 64) begin
            remainders[n] = rde_pkg::RADIX_W'(quotient % radix);
            quotient = quotient / radix;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            txn = '{digit_char: digit_symbol(remainders[k]),
                    last_digit: (k == 0), bad_radix: 1'b0};
            expected_digits.push_back(txn);
        end
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_digit_txn got;
        t_digit_txn want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                convert_value(i_s_tdata[63:0], i_s_tdata[69:64]);
                values_taken++;
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '{digit_char: i_m_tdata[rde_pkg::CHAR_W-1:0], last_digit: i_m_tuser[0],
                        bad_radix: i_m_tuser[1]};
                digits_taken++;
                if (got.bad_radix) begin
                    bad_radix_taken++;
                end
                if (expected_digits.size() == 0) begin
                    $error("unexpected transaction: digit_char %0d last_digit %0d bad_radix %0d",
                           got.digit_char, got.last_digit, got.bad_radix);
                    fail_count++;
                end else begin
                    want = expected_digits.pop_front();
                    check_field("digit_char", want.digit_char, got.digit_char);
                    check_field("last_digit", want.last_digit, got.last_digit);
                    check_field("bad_radix", want.bad_radix, got.bad_radix);
                end
            end
        end
        pending = expected_digits.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the radix digit emitter: clock, reset, value stimulus and
// receiver stalls. Depends on rde_pkg, radix_digit_emitter and rde_checker.
module tb_top;

    localparam int VALUE_BITS   = rde_pkg::VALUE_BITS_DEF;
    localparam int RANDOM_ITEMS = 460;
    localparam int HOLD_CYCLES  = 2500;
    localparam int CYCLE_LIMIT  = 20_000_000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic [1:0]  o_m_tuser;

    int fail_count;
    int pending;
    int values_taken;
    int digits_taken;
    int bad_radix_taken;
    int cycle_count = 0;

    radix_digit_emitter #(.VALUE_BITS(VALUE_BITS)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    rde_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_s_tdata         (i_s_tdata),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_m_tdata         (o_m_tdata),
        .i_m_tuser         (o_m_tuser),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_values_taken    (values_taken),
        .o_digits_taken    (digits_taken),
        .o_bad_radix_taken (bad_radix_taken)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digits still expected",
                     cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short idles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Mostly narrow values, so digit strings stay short; some use all 64 bits.
    function automatic logic [63:0] pick_value();
        int          r;
        int          w;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 70) w = $urandom_range(1, 16);
        else if (r < 88) w = $urandom_range(17, 40);
        else w = 64;
        v = {$urandom, $urandom};
        if (w < 64) v = v & ((64'd1 << w) - 1);
        return v;
    endfunction

    function automatic logic [rde_pkg::RADIX_W-1:0] pick_radix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return 6'd0;
        if (r < 4) return 6'd1;
        if (r < 6) return 6'd63;
        return rde_pkg::RADIX_W'($urandom_range(rde_pkg::RADIX_MIN, rde_pkg::RADIX_MAX));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_value(input logic [63:0] value,
                              input logic [rde_pkg::RADIX_W-1:0] radix,
                              input bit quiet);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, radix, value};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off so the
    // block backs up and keeps its input stalled.
    initial begin : receiver
        bit held_off;
        int stall;
        held_off = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!held_off && digits_taken >= 120) begin
                held_off = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 15) == 0) repeat ($urandom_range(100, 400)) @(negedge i_clk);
            else repeat ($urandom_range(1, 30)) @(negedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int quiet_left;
        quiet_left = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Corner values and radices, the out-of-range radices and the zero value.
        send_value(64'd12345, 6'd0, 1'b0);
        send_value(64'd0, 6'd1, 1'b0);
        send_value({64{1'b1}}, 6'd63, 1'b0);
        send_value(64'd0, 6'd10, 1'b0);
        send_value(64'd0, rde_pkg::RADIX_MAX, 1'b0);
        send_value(64'd1, rde_pkg::RADIX_MIN, 1'b0);
        send_value({64{1'b1}}, rde_pkg::RADIX_MIN, 1'b0);
        send_value(64'h8000_0000_0000_0000, rde_pkg::RADIX_MIN, 1'b1);
        send_value({64{1'b1}}, rde_pkg::RADIX_MAX, 1'b1);
        send_value(64'd61, rde_pkg::RADIX_MAX, 1'b0);
        send_value(64'd62, rde_pkg::RADIX_MAX, 1'b0);
        send_value(64'd60, 6'd61, 1'b0);
        send_value(64'd35, 6'd36, 1'b0);
        send_value(64'hDEAD_BEEF_0123_4567, 6'd16, 1'b0);
        send_value(64'd9, 6'd10, 1'b0);
        send_value(64'd123456789, 6'd10, 1'b0);
        send_value({64{1'b1}}, 6'd3, 1'b0);
        send_value(64'o1234567, 6'd8, 1'b0);
        send_value(64'h5555_5555_5555_5555, 6'd36, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (quiet_left == 0 && $urandom_range(0, 19) == 0) begin
                quiet_left = $urandom_range(10, 40);
            end
            send_value(pick_value(), pick_radix(), quiet_left > 0);
            if (quiet_left > 0) quiet_left--;
        end
        i_s_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        // let any trailing zero-value item drain
        repeat (4 * (VALUE_BITS + 4)) @(posedge i_clk);

        $display("Converted %0d values over radices 0 to 63, including hold-off backpressure.",
                 values_taken);
        $display("Checked %0d output transactions, %0d of them bad-radix flags.",
                 digits_taken, bad_radix_taken);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
